### rtl/core/region_registration_table_core_macros.svh
// ---------------------------------------------------------------------------
// Region registration table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef REGION_REGISTRATION_TABLE_CORE_MACROS_SVH
`define REGION_REGISTRATION_TABLE_CORE_MACROS_SVH

// check that a condition implies another in the same cycle
`define RRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("region table check failed");

// check that a condition holds in every cycle
`define RRT_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("region table check failed");

`endif

### rtl/core/rrt_pkg.sv
// ---------------------------------------------------------------------------
// Region registration table package
// Shared codes, control structs and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int RANK_COUNT_DEF    = 256;
	localparam int ADDRESS_WIDTH_DEF = 48;
	localparam int LENGTH_WIDTH_DEF  = 40;
	localparam int RANK_W            = 8;

	typedef enum logic [1:0] {
		FN_CONTAIN   = 2'd0,
		FN_INTERSECT = 2'd1,
		FN_INSERT    = 2'd2,
		FN_REMOVE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_DUP       = 2'd3
	} status_t;

	// control part of the beat walking the chain
	typedef struct packed {
		logic  tok;
		func_t func;
		logic  rank_ok;
		logic  found;
		logic  free_found;
	} ctl_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic en;
		logic clear;
	} wr_t;

endpackage

`default_nettype wire

### rtl/core/region_registration_table_core.sv
// ---------------------------------------------------------------------------
// Region registration table core
// Table of owner-tagged memory regions with insert, remove and range lookups.
// ---------------------------------------------------------------------------
// Each accepted beat walks a chain of TABLE_ENTRIES cells, one cell per clock,
// and each cell compares the query with the one entry it holds. The result
// beat is registered once the beat leaves the last cell, and the block takes
// the next input beat only once the result beat is taken, so only one item is
// in flight at a time. Inserts and removes update the table in the same cycle
// the result is registered. The table holds no entries after reset; no clearing
// pass is needed.
`default_nettype none

`include "region_registration_table_core_macros.svh"

module region_registration_table_core #(
	parameter int TABLE_ENTRIES = rrt_pkg::TABLE_ENTRIES_DEF,
	parameter int RANK_COUNT    = rrt_pkg::RANK_COUNT_DEF,
	parameter int ADDRESS_WIDTH = rrt_pkg::ADDRESS_WIDTH_DEF,
	parameter int LENGTH_WIDTH  = rrt_pkg::LENGTH_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [1:0]                        func,
	input  wire [rrt_pkg::RANK_W-1:0]        rank,
	input  wire [ADDRESS_WIDTH-1:0]          base_address,
	input  wire [LENGTH_WIDTH-1:0]           length,
	input  wire [ADDRESS_WIDTH-1:0]          mapped_address,
	input  wire                              device_flag,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [1:0]                       status,
	output logic [$clog2(TABLE_ENTRIES)-1:0] hit_slot,
	output logic [ADDRESS_WIDTH-1:0]         hit_base,
	output logic [LENGTH_WIDTH-1:0]          hit_length,
	output logic [ADDRESS_WIDTH-1:0]         hit_mapped,
	output logic                             hit_device_flag
);
	import rrt_pkg::*;

	localparam int N  = TABLE_ENTRIES;
	localparam int SW = $clog2(TABLE_ENTRIES);
	localparam int EW = ((ADDRESS_WIDTH > LENGTH_WIDTH) ? ADDRESS_WIDTH : LENGTH_WIDTH) + 1;

	// chain taps: index 0 feeds the first cell, index N leaves the last
	ctl_t                     ctl_a     [0:N];
	logic [RANK_W-1:0]        rank_a    [0:N];
	logic [ADDRESS_WIDTH-1:0] base_a    [0:N];
	logic [EW-1:0]            qend_a    [0:N];
	logic [LENGTH_WIDTH-1:0]  len_a     [0:N];
	logic [ADDRESS_WIDTH-1:0] mapped_a  [0:N];
	logic                     dev_a     [0:N];
	logic [SW-1:0]            bslot_a   [0:N];
	logic [ADDRESS_WIDTH-1:0] bbase_a   [0:N];
	logic [LENGTH_WIDTH-1:0]  blen_a    [0:N];
	logic [ADDRESS_WIDTH-1:0] bmapped_a [0:N];
	logic                     bdev_a    [0:N];
	logic [SW-1:0]            fslot_a   [0:N];
	logic [N-1:0]             tok_vec;
	logic [N-1:0]             valid_vec;

	logic                     busy_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic [SW-1:0]            slot_q;
	logic [ADDRESS_WIDTH-1:0] hbase_q;
	logic [LENGTH_WIDTH-1:0]  hlen_q;
	logic [ADDRESS_WIDTH-1:0] hmapped_q;
	logic                     hdev_q;

	logic                     in_acc, out_acc, done;
	wr_t                      wr;
	logic [SW-1:0]            wr_slot;
	status_t                  st_d;
	logic                     ins_ok;
	logic [LENGTH_WIDTH-1:0]  qlen;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_acc  = out_valid_q && !out_stall;

	// launch the beat into the first cell; a zero-length query counts as one byte
	assign qlen         = (length == '0) ? LENGTH_WIDTH'(1) : length;
	assign ctl_a[0]     = {in_acc, func_t'(func), (17'(rank) < 17'(RANK_COUNT)), 1'b0, 1'b0};
	assign rank_a[0]    = rank;
	assign base_a[0]    = base_address;
	assign qend_a[0]    = EW'(base_address) + EW'(qlen);
	assign len_a[0]     = length;
	assign mapped_a[0]  = mapped_address;
	assign dev_a[0]     = device_flag;
	assign bslot_a[0]   = '0;
	assign bbase_a[0]   = '0;
	assign blen_a[0]    = '0;
	assign bmapped_a[0] = '0;
	assign bdev_a[0]    = 1'b0;
	assign fslot_a[0]   = '0;

	// slot written by the finishing beat: free slot on insert, match on remove
	assign wr_slot = (ctl_a[N].func == FN_INSERT) ? fslot_a[N] : bslot_a[N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		rrt_cell #(
			.IDX          (i),
			.SW           (SW),
			.ADDRESS_WIDTH(ADDRESS_WIDTH),
			.LENGTH_WIDTH (LENGTH_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl_in     (ctl_a[i]),
			.rank_in    (rank_a[i]),
			.base_in    (base_a[i]),
			.qend_in    (qend_a[i]),
			.len_in     (len_a[i]),
			.mapped_in  (mapped_a[i]),
			.dev_in     (dev_a[i]),
			.bslot_in   (bslot_a[i]),
			.bbase_in   (bbase_a[i]),
			.blen_in    (blen_a[i]),
			.bmapped_in (bmapped_a[i]),
			.bdev_in    (bdev_a[i]),
			.fslot_in   (fslot_a[i]),
			.ctl_out    (ctl_a[i+1]),
			.rank_out   (rank_a[i+1]),
			.base_out   (base_a[i+1]),
			.qend_out   (qend_a[i+1]),
			.len_out    (len_a[i+1]),
			.mapped_out (mapped_a[i+1]),
			.dev_out    (dev_a[i+1]),
			.bslot_out  (bslot_a[i+1]),
			.bbase_out  (bbase_a[i+1]),
			.blen_out   (blen_a[i+1]),
			.bmapped_out(bmapped_a[i+1]),
			.bdev_out   (bdev_a[i+1]),
			.fslot_out  (fslot_a[i+1]),
			.wr         (wr),
			.wr_slot    (wr_slot),
			.wr_rank    (rank_a[N]),
			.wr_base    (base_a[N]),
			.wr_len     (len_a[N]),
			.wr_mapped  (mapped_a[N]),
			.wr_dev     (dev_a[N]),
			.valid_out  (valid_vec[i])
		);
		assign tok_vec[i] = ctl_a[i+1].tok;
	end

	// resolve the beat leaving the last cell
	always_comb begin
		done   = ctl_a[N].tok;
		ins_ok = 1'b0;
		wr     = '0;
		if (!ctl_a[N].rank_ok) begin
			st_d = ST_NOT_FOUND;
		end else begin
			case (ctl_a[N].func)
				FN_INSERT: begin
					if (ctl_a[N].found) begin
						st_d = ST_DUP;
					end else if (!ctl_a[N].free_found) begin
						st_d = ST_FULL;
					end else begin
						st_d   = ST_OK;
						ins_ok = 1'b1;
					end
				end
				default: begin
					st_d = ctl_a[N].found ? ST_OK : ST_NOT_FOUND;
				end
			endcase
		end
		if (done && ins_ok) begin
			wr.en = 1'b1;
		end
		if (done && ctl_a[N].rank_ok && ctl_a[N].found && (ctl_a[N].func == FN_REMOVE)) begin
			wr.en    = 1'b1;
			wr.clear = 1'b1;
		end
	end

	// hold busy from input accept until the result beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (out_acc) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// failed operations report zero fields; a removed entry reports its old contents
	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= st_d;
			if (st_d != ST_OK) begin
				slot_q    <= '0;
				hbase_q   <= '0;
				hlen_q    <= '0;
				hmapped_q <= '0;
				hdev_q    <= 1'b0;
			end else if (ins_ok) begin
				slot_q    <= fslot_a[N];
				hbase_q   <= base_a[N];
				hlen_q    <= len_a[N];
				hmapped_q <= mapped_a[N];
				hdev_q    <= dev_a[N];
			end else begin
				slot_q    <= bslot_a[N];
				hbase_q   <= bbase_a[N];
				hlen_q    <= blen_a[N];
				hmapped_q <= bmapped_a[N];
				hdev_q    <= bdev_a[N];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign hit_slot        = slot_q;
	assign hit_base        = hbase_q;
	assign hit_length      = hlen_q;
	assign hit_mapped      = hmapped_q;
	assign hit_device_flag = hdev_q;

	// exactly one beat is in flight while busy, none otherwise
	`RRT_ASSERT_ALWAYS(a_one_beat, busy_q == ($countones({tok_vec, out_valid_q}) == 1))
	// a result beat only follows the beat leaving the last cell
	`RRT_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(tok_vec[N-1]))
	// a removed slot was valid and an inserted slot was free
	`RRT_ASSERT_IMP(a_wr_slot, wr.en, valid_vec[wr_slot] == wr.clear)

endmodule

`default_nettype wire

### rtl/core/rrt_cell.sv
// ---------------------------------------------------------------------------
// Region registration table cell
// Holds one table entry and advances the query beat by one cell.
// ---------------------------------------------------------------------------
`default_nettype none

module rrt_cell #(
	parameter int IDX           = 0,
	parameter int SW            = 6,
	parameter int ADDRESS_WIDTH = 48,
	parameter int LENGTH_WIDTH  = 40
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  rrt_pkg::ctl_t            ctl_in,
	input  wire [rrt_pkg::RANK_W-1:0] rank_in,
	input  wire [ADDRESS_WIDTH-1:0]  base_in,
	input  wire [((ADDRESS_WIDTH > LENGTH_WIDTH) ? ADDRESS_WIDTH : LENGTH_WIDTH):0] qend_in,
	input  wire [LENGTH_WIDTH-1:0]   len_in,
	input  wire [ADDRESS_WIDTH-1:0]  mapped_in,
	input  wire                      dev_in,
	input  wire [SW-1:0]             bslot_in,
	input  wire [ADDRESS_WIDTH-1:0]  bbase_in,
	input  wire [LENGTH_WIDTH-1:0]   blen_in,
	input  wire [ADDRESS_WIDTH-1:0]  bmapped_in,
	input  wire                      bdev_in,
	input  wire [SW-1:0]             fslot_in,
	output rrt_pkg::ctl_t            ctl_out,
	output logic [rrt_pkg::RANK_W-1:0] rank_out,
	output logic [ADDRESS_WIDTH-1:0] base_out,
	output logic [((ADDRESS_WIDTH > LENGTH_WIDTH) ? ADDRESS_WIDTH : LENGTH_WIDTH):0] qend_out,
	output logic [LENGTH_WIDTH-1:0]  len_out,
	output logic [ADDRESS_WIDTH-1:0] mapped_out,
	output logic                     dev_out,
	output logic [SW-1:0]            bslot_out,
	output logic [ADDRESS_WIDTH-1:0] bbase_out,
	output logic [LENGTH_WIDTH-1:0]  blen_out,
	output logic [ADDRESS_WIDTH-1:0] bmapped_out,
	output logic                     bdev_out,
	output logic [SW-1:0]            fslot_out,
	input  rrt_pkg::wr_t             wr,
	input  wire [SW-1:0]             wr_slot,
	input  wire [rrt_pkg::RANK_W-1:0] wr_rank,
	input  wire [ADDRESS_WIDTH-1:0]  wr_base,
	input  wire [LENGTH_WIDTH-1:0]   wr_len,
	input  wire [ADDRESS_WIDTH-1:0]  wr_mapped,
	input  wire                      wr_dev,
	output logic                     valid_out
);
	import rrt_pkg::*;

	localparam int EW = ((ADDRESS_WIDTH > LENGTH_WIDTH) ? ADDRESS_WIDTH : LENGTH_WIDTH) + 1;

	logic                     valid_q;
	logic [RANK_W-1:0]        owner_q;
	logic [ADDRESS_WIDTH-1:0] base_q;
	logic [LENGTH_WIDTH-1:0]  len_q;
	logic [ADDRESS_WIDTH-1:0] mapped_q;
	logic                     dev_q;

	ctl_t                     ctl_s1;
	logic [RANK_W-1:0]        rank_s1;
	logic [ADDRESS_WIDTH-1:0] base_s1;
	logic [EW-1:0]            qend_s1;
	logic [LENGTH_WIDTH-1:0]  len_s1;
	logic [ADDRESS_WIDTH-1:0] mapped_s1;
	logic                     dev_s1;
	logic [SW-1:0]            bslot_s1;
	logic [ADDRESS_WIDTH-1:0] bbase_s1;
	logic [LENGTH_WIDTH-1:0]  blen_s1;
	logic [ADDRESS_WIDTH-1:0] bmapped_s1;
	logic                     bdev_s1;
	logic [SW-1:0]            fslot_s1;

	logic [EW-1:0] rbeg, qbeg, rend;
	logic          own, cand, take, free_take;
	ctl_t          ctl_d;

	always_comb begin
		rbeg = EW'(base_q);
		qbeg = EW'(base_in);
		rend = EW'(base_q) + EW'(len_q);
		own  = valid_q && (owner_q == rank_in);
		case (ctl_in.func)
			FN_CONTAIN:   cand = own && (rbeg <= qbeg) && (qend_in <= rend);
			FN_INTERSECT: cand = own && (((qbeg <= rbeg) && (rbeg < qend_in)) ||
				((qbeg < rend) && (rend <= qend_in)));
			default:      cand = own && (base_q == base_in);
		endcase
		// contain keeps the lowest base, intersect the highest, exact the first
		case (ctl_in.func)
			FN_CONTAIN:   take = cand && (!ctl_in.found || (base_q < bbase_in));
			FN_INTERSECT: take = cand && (!ctl_in.found || (base_q > bbase_in));
			default:      take = cand && !ctl_in.found;
		endcase
		free_take = !valid_q && !ctl_in.free_found;
		ctl_d            = ctl_in;
		ctl_d.found      = ctl_in.found || take;
		ctl_d.free_found = ctl_in.free_found || free_take;
	end

	// hold the entry; update on a broadcast write to this slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr_slot == SW'(IDX))) begin
			valid_q <= !wr.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && !wr.clear && (wr_slot == SW'(IDX))) begin
			owner_q  <= wr_rank;
			base_q   <= wr_base;
			len_q    <= wr_len;
			mapped_q <= wr_mapped;
			dev_q    <= wr_dev;
		end
	end

	// advance the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		rank_s1   <= rank_in;
		base_s1   <= base_in;
		qend_s1   <= qend_in;
		len_s1    <= len_in;
		mapped_s1 <= mapped_in;
		dev_s1    <= dev_in;
		if (take) begin
			bslot_s1   <= SW'(IDX);
			bbase_s1   <= base_q;
			blen_s1    <= len_q;
			bmapped_s1 <= mapped_q;
			bdev_s1    <= dev_q;
		end else begin
			bslot_s1   <= bslot_in;
			bbase_s1   <= bbase_in;
			blen_s1    <= blen_in;
			bmapped_s1 <= bmapped_in;
			bdev_s1    <= bdev_in;
		end
		fslot_s1 <= free_take ? SW'(IDX) : fslot_in;
	end

	assign ctl_out     = ctl_s1;
	assign rank_out    = rank_s1;
	assign base_out    = base_s1;
	assign qend_out    = qend_s1;
	assign len_out     = len_s1;
	assign mapped_out  = mapped_s1;
	assign dev_out     = dev_s1;
	assign bslot_out   = bslot_s1;
	assign bbase_out   = bbase_s1;
	assign blen_out    = blen_s1;
	assign bmapped_out = bmapped_s1;
	assign bdev_out    = bdev_s1;
	assign fslot_out   = fslot_s1;
	assign valid_out   = valid_q;

endmodule

`default_nettype wire

### verif/tb_region_registration_table_core.sv
// ---------------------------------------------------------------------------
// Region registration table core testbench
// Drives insert, remove and range lookups against an internal table predictor
// and compares every result beat field by field, under random idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_region_registration_table_core;
	import rrt_pkg::*;

	localparam int ENTRIES = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		func_t       func;
		logic [7:0]  rank;
		logic [47:0] base;
		logic [39:0] len;
		logic [47:0] mapped;
		logic        dev;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [47:0] base;
		logic [39:0] len;
		logic [47:0] mapped;
		logic        dev;
	} reply_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic [7:0] rank;
	logic [47:0] base_address, mapped_address;
	logic [39:0] length;
	logic device_flag;
	logic [1:0] status;
	logic [5:0] hit_slot;
	logic [47:0] hit_base, hit_mapped;
	logic [39:0] hit_length;
	logic hit_device_flag;
	logic in_taken_q = 1'b0;

	// predictor copy of the region table
	logic        tbl_used [ENTRIES];
	logic [7:0]  tbl_owner [ENTRIES];
	logic [47:0] tbl_base [ENTRIES];
	logic [39:0] tbl_len [ENTRIES];
	logic [47:0] tbl_mapped [ENTRIES];
	logic        tbl_dev [ENTRIES];

	request_t pending_requests[$];
	reply_t   expected_replies[$];
	logic [47:0] known_bases[$];
	logic [7:0]  known_ranks[$];

	int mismatches = 0;
	int accepted_in = 0;
	int accepted_out = 0;
	int idle_cycles = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 70;
	bit timed_out = 0;
	int op_count [4] = '{0, 0, 0, 0};

	region_registration_table_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .rank(rank), .base_address(base_address), .length(length),
		.mapped_address(mapped_address), .device_flag(device_flag),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit_slot(hit_slot), .hit_base(hit_base),
		.hit_length(hit_length), .hit_mapped(hit_mapped),
		.hit_device_flag(hit_device_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reply_t hit_reply(input int s);
		reply_t r;
		r.status = ST_OK;
		r.slot = s[5:0];
		r.base = tbl_base[s];
		r.len = tbl_len[s];
		r.mapped = tbl_mapped[s];
		r.dev = tbl_dev[s];
		return r;
	endfunction

	// compute the reply of one request and apply it to the predicted table
	function automatic reply_t table_lookup_update(input request_t q);
		reply_t r;
		logic [48:0] qbeg, qend, rbeg, rend;
		int best;
		bit hit;
		r = '0;
		r.status = ST_NOT_FOUND;
		best = -1;
		qbeg = {1'b0, q.base};
		qend = qbeg + ((q.len == 0) ? 49'd1 : {9'd0, q.len});
		if (q.func == FN_CONTAIN || q.func == FN_INTERSECT) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!tbl_used[i] || tbl_owner[i] != q.rank) continue;
				rbeg = {1'b0, tbl_base[i]};
				rend = rbeg + {9'd0, tbl_len[i]};
				if (q.func == FN_CONTAIN)
					hit = (rbeg <= qbeg) && (qend <= rend);
				else
					hit = ((qbeg <= rbeg) && (rbeg < qend)) ||
						((qbeg < rend) && (rend <= qend));
				if (!hit) continue;
				if (best < 0 || (q.func == FN_CONTAIN ? tbl_base[i] < tbl_base[best]
						: tbl_base[i] > tbl_base[best]))
					best = i;
			end
			if (best >= 0) r = hit_reply(best);
			return r;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_used[i] && tbl_owner[i] == q.rank && tbl_base[i] == q.base) begin
				best = i;
				break;
			end
		end
		if (q.func == FN_REMOVE) begin
			if (best >= 0) begin
				r = hit_reply(best);
				tbl_used[best] = 1'b0;
			end
			return r;
		end
		if (best >= 0) begin
			r.status = ST_DUP;
			return r;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_used[i]) begin
				tbl_used[i] = 1'b1;
				tbl_owner[i] = q.rank;
				tbl_base[i] = q.base;
				tbl_len[i] = q.len;
				tbl_mapped[i] = q.mapped;
				tbl_dev[i] = q.dev;
				return hit_reply(i);
			end
		end
		r.status = ST_FULL;
		return r;
	endfunction

	function automatic logic [47:0] rand_addr();
		return {16'($urandom_range(65535, 0)), $urandom()};
	endfunction

	function automatic logic [39:0] rand_len();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return 40'($urandom_range(16, 1));
			2: return 40'($urandom_range(4096, 1));
			default: return {8'($urandom_range(255, 0)), $urandom()};
		endcase
	endfunction

	task automatic queue_request(input func_t f, input logic [7:0] rk, input logic [47:0] b,
			input logic [39:0] l, input logic [47:0] m, input logic d);
		request_t q;
		q.func = f;
		q.rank = rk;
		q.base = b;
		q.len = l;
		q.mapped = m;
		q.dev = d;
		pending_requests.push_back(q);
		if (f == FN_INSERT) begin
			known_bases.push_back(b);
			known_ranks.push_back(rk);
		end
	endtask

	// well-formed traffic: mostly requests near previously inserted bases
	task automatic queue_random_request();
		int k, pick;
		logic [47:0] b;
		logic [7:0] rk;
		pick = $urandom_range(99, 0);
		if (known_bases.size() == 0 || pick < 8) begin
			queue_request(FN_INSERT, 8'($urandom_range(255, 0)), rand_addr(), rand_len(),
				rand_addr(), 1'($urandom()));
			return;
		end
		k = $urandom_range(known_bases.size() - 1, 0);
		b = known_bases[k];
		rk = ($urandom_range(9, 0) == 0) ? 8'($urandom()) : known_ranks[k];
		if (pick < 35)
			queue_request(FN_INSERT, rk, ($urandom_range(3, 0) == 0) ? b
				: b + 48'($urandom_range(8192, 0)), rand_len(), rand_addr(),
				1'($urandom()));
		else if (pick < 55)
			queue_request(FN_REMOVE, rk, ($urandom_range(4, 0) == 0) ? rand_addr() : b,
				rand_len(), rand_addr(), 1'($urandom()));
		else
			queue_request(($urandom_range(1, 0) == 0) ? FN_CONTAIN : FN_INTERSECT, rk,
				b + 48'($urandom_range(64, 0)) - 48'd16, rand_len(), rand_addr(),
				1'($urandom()));
	endtask

	// remember whether the presented beat was taken at the last rising edge
	always @(posedge clk) begin
		in_taken_q <= arst_n && in_valid && !in_stall;
	end

	// driver: present beats at the falling edge, hold until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken_q) begin
				if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					request_t q;
					q = pending_requests.pop_front();
					in_valid <= 1'b1;
					func <= q.func;
					rank <= q.rank;
					base_address <= q.base;
					length <= q.len;
					mapped_address <= q.mapped;
					device_flag <= q.dev;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// monitor: predict on accepted input beats, check accepted result beats
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0
				: idle_cycles + 1;
			if (in_valid && !in_stall) begin
				request_t q;
				q.func = func_t'(func);
				q.rank = rank;
				q.base = base_address;
				q.len = length;
				q.mapped = mapped_address;
				q.dev = device_flag;
				expected_replies.push_back(table_lookup_update(q));
				op_count[func] <= op_count[func] + 1;
				accepted_in <= accepted_in + 1;
			end
			if (out_valid && !out_stall) begin
				reply_t got, want;
				got = {status_t'(status), hit_slot, hit_base, hit_length, hit_mapped,
					hit_device_flag};
				accepted_out <= accepted_out + 1;
				if (expected_replies.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("ERROR: unexpected result beat status=%0d slot=%0d",
							status, hit_slot);
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display({"ERROR: result mismatch\n  exp st=%0d slot=%0d b=%h l=%h",
								" m=%h d=%0d\n  got st=%0d slot=%0d b=%h l=%h m=%h d=%0d"},
								want.status, want.slot, want.base, want.len, want.mapped,
								want.dev, got.status, got.slot, got.base, got.len,
								got.mapped, got.dev);
					end
				end
			end
		end
	end

	// stop the run if nothing moves for too long
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int n;
		in_valid = 1'b0;
		out_stall = 1'b0;
		func = '0;
		rank = '0;
		base_address = '0;
		length = '0;
		mapped_address = '0;
		device_flag = 1'b0;
		for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n = 1'b1;

		// directed: empty-table misses, extremes, duplicates, zero lengths
		queue_request(FN_CONTAIN, 8'd0, 48'd0, 40'd0, 48'd0, 1'b0);
		queue_request(FN_REMOVE, 8'd255, '1, '1, '1, 1'b1);
		queue_request(FN_INSERT, 8'd0, 48'd0, 40'd0, '1, 1'b1);
		queue_request(FN_INSERT, 8'd255, '1, '1, '1, 1'b1);
		queue_request(FN_INSERT, 8'd255, '1, 40'd5, 48'd0, 1'b0);
		queue_request(FN_CONTAIN, 8'd255, '1, '1, 48'd0, 1'b0);
		queue_request(FN_INTERSECT, 8'd255, 48'hFFFF_FFFF_FF00, 40'h100, 48'd0, 1'b0);
		queue_request(FN_INTERSECT, 8'd0, 48'd0, 40'd0, 48'd0, 1'b0);
		queue_request(FN_CONTAIN, 8'd0, 48'd0, 40'd0, 48'd0, 1'b0);
		queue_request(FN_INSERT, 8'd7, 48'h1000, 40'h1000, 48'hAAAA, 1'b0);
		queue_request(FN_INSERT, 8'd7, 48'h1800, 40'h100, 48'h5555, 1'b1);
		queue_request(FN_INSERT, 8'd7, 48'h0800, 40'h2000, 48'h1234, 1'b0);
		queue_request(FN_CONTAIN, 8'd7, 48'h1810, 40'h10, 48'd0, 1'b0);
		queue_request(FN_INTERSECT, 8'd7, 48'h1000, 40'h900, 48'd0, 1'b0);
		queue_request(FN_CONTAIN, 8'd8, 48'h1810, 40'h10, 48'd0, 1'b0);
		queue_request(FN_REMOVE, 8'd7, 48'h1800, 40'd0, 48'd0, 1'b0);
		queue_request(FN_REMOVE, 8'd7, 48'h1800, 40'd0, 48'd0, 1'b0);
		queue_request(FN_INSERT, 8'd7, 48'h1800, 40'h10, 48'h77, 1'b1);
		// fill the table, then hit full and duplicate-on-full
		for (int i = 0; i < ENTRIES; i++)
			queue_request(FN_INSERT, 8'd9, 48'h10_0000 + 48'(i) * 48'h100, 40'h80,
				rand_addr(), 1'($urandom()));
		queue_request(FN_INSERT, 8'd9, 48'h10_0000, 40'h80, 48'd0, 1'b0);
		queue_request(FN_INSERT, 8'd9, 48'h20_0000, 40'h80, 48'd0, 1'b0);
		for (int i = 0; i < 62; i++)
			queue_request(FN_REMOVE, 8'd9, 48'h10_0000 + 48'(i) * 48'h100, 40'd0, 48'd0,
				1'b0);

		// random part in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
			recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 30 : 0;
			n = (phase == 2) ? 160 : 170;
			for (int i = 0; i < n; i++) queue_random_request();
			wait (pending_requests.size() == 0);
		end

		wait (expected_replies.size() == 0 && !(in_valid && in_stall));
		repeat (2 * ENTRIES + 10) @(posedge clk);
		$display("Covered %0d input beats (contain %0d, intersect %0d, insert %0d, remove %0d)",
			accepted_in, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("Checked %0d result beats, %0d mismatches", accepted_out, mismatches);
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
